// ===== rtl/grid_point_mesh_triangulator_assert.svh =====
// Assertion macros for the grid point mesh triangulator.
`ifndef GRID_POINT_MESH_TRIANGULATOR_ASSERT_SVH
`define GRID_POINT_MESH_TRIANGULATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define GPMT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequence is checked in the clock cycle after the antecedent.
`define GPMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/gpmt_pkg.sv =====
// Package with the shared types and constants of the grid point mesh triangulator.
package gpmt_pkg;
  localparam int COORD_BITS = 24;
  localparam int MAX_ROW_POINTS = 64;
  localparam int COL_BITS = $clog2(MAX_ROW_POINTS);
  localparam int LEN_BITS = COL_BITS + 1;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int SUM_BITS = 2 * DIFF_BITS + 2;
  localparam int ROOT_BITS = SUM_BITS / 2;
  localparam int PERIM_BITS = 28;
  localparam int PER_SUM_BITS = ROOT_BITS + 2;
  localparam logic [PERIM_BITS-1:0] PERIM_RESET = 28'd89600;
  localparam int ADDR_BITS = 3;
  localparam logic [ADDR_BITS-1:0] REG_MAX_PERIMETER = 3'd0;
  localparam logic [ADDR_BITS-1:0] REG_LINEAR_MODE = 3'd4;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t pz;
    logic mesh_start;
    logic row_end;
  } in_word_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
    logic is_segment;
    logic last;
  } out_word_t;

  // Handshake between the sequencer and the edge length unit.
  typedef struct packed {
    logic start;
    point_t p;
    point_t q;
  } len_req_t;

  typedef struct packed {
    logic done;
    logic [ROOT_BITS-1:0] root;
  } len_rsp_t;
endpackage

// ===== rtl/gpmt_edge_len.sv =====
// Edge length unit: bit-serial squared distance and a restoring square root.
module gpmt_edge_len (
  input  logic              clk,
  input  logic              rst_n,
  input  gpmt_pkg::len_req_t req,
  output gpmt_pkg::len_rsp_t rsp
);
  localparam int DB = gpmt_pkg::DIFF_BITS;
  localparam int SB = gpmt_pkg::SUM_BITS;
  localparam int RB = gpmt_pkg::ROOT_BITS;
  localparam int CNT_BITS = $clog2(SB + 1);

  typedef enum logic [1:0] {S_IDLE, S_SQ, S_ROOT} state_t;

  state_t state_r;
  logic [1:0] axis_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [DB-1:0] mcand_r;
  logic [DB-1:0] mplier_r;
  logic [SB-1:0] sum_r;
  logic [SB-1:0] rem_r;
  logic [RB-1:0] root_r;
  logic done_r;
  gpmt_pkg::point_t p_r, q_r;

  logic [DB-1:0] diff;
  logic [DB-1:0] mag;
  logic [SB+1:0] trial_rem;
  logic [SB+1:0] trial_sub;

  always_comb begin
    case (axis_r)
      2'd0: diff = DB'(p_r.x) - DB'(q_r.x);
      2'd1: diff = DB'(p_r.y) - DB'(q_r.y);
      default: diff = DB'(p_r.z) - DB'(q_r.z);
    endcase
    mag = diff[DB-1] ? (~diff + DB'(1)) : diff;
    // Each step brings down the next radicand digit pair and decides the next result bit.
    trial_rem = {rem_r, sum_r[SB-1:SB-2]};
    trial_sub = trial_rem - {{(SB-RB){1'b0}}, root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r <= 1'b0;
      axis_r <= 2'd0;
      cnt_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          done_r <= 1'b0;
          if (req.start) begin
            p_r <= req.p;
            q_r <= req.q;
            axis_r <= 2'd0;
            cnt_r <= '0;
            sum_r <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          // Shift-and-add square, one multiplier bit per cycle.
          if (cnt_r == '0) begin
            mcand_r <= mag;
            mplier_r <= mag;
            cnt_r <= CNT_BITS'(1);
          end else begin
            if (mplier_r[0]) begin
              sum_r <= sum_r + (SB'(mcand_r) << (cnt_r - CNT_BITS'(1)));
            end
            mplier_r <= mplier_r >> 1;
            if (cnt_r == CNT_BITS'(DB)) begin
              cnt_r <= '0;
              if (axis_r == 2'd2) begin
                rem_r <= '0;
                root_r <= '0;
                state_r <= S_ROOT;
              end else begin
                axis_r <= axis_r + 2'd1;
              end
            end else begin
              cnt_r <= cnt_r + CNT_BITS'(1);
            end
          end
        end
        S_ROOT: begin
          sum_r <= sum_r << 2;
          if (!trial_sub[SB+1]) begin
            rem_r <= trial_sub[SB-1:0];
            root_r <= {root_r[RB-2:0], 1'b1};
          end else begin
            rem_r <= trial_rem[SB-1:0];
            root_r <= {root_r[RB-2:0], 1'b0};
          end
          if (cnt_r == CNT_BITS'(RB - 1)) begin
            done_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            done_r <= 1'b0;
          end
          cnt_r <= cnt_r + CNT_BITS'(1);
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;
endmodule

// ===== rtl/grid_point_mesh_triangulator.sv =====
// Grid point mesh triangulator: takes one point at a time and emits triangles or
// segments whose perimeter (or length) is within max_perimeter. A point is accepted
// only while the block is idle. Each edge length goes through one shared bit-serial
// unit: three squaring passes and 26 square root steps. A segment needs one edge and
// a quad five, since the shared diagonal is measured once; a point also holds the
// block while a waiting result word is stalled. The line store is a 64-entry memory
// read and written once per point that is not dropped. No clearing pass is needed
// after reset.
module grid_point_mesh_triangulator (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  gpmt_pkg::in_word_t     in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output gpmt_pkg::out_word_t    out_data,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [gpmt_pkg::ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  localparam int CB = gpmt_pkg::COL_BITS;
  localparam int LB = gpmt_pkg::LEN_BITS;
  localparam int PB = gpmt_pkg::PER_SUM_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EDGE, S_WAIT, S_OUT1, S_OUT2
  } state_t;

  state_t state_r;
  logic [gpmt_pkg::PERIM_BITS-1:0] max_per_r;
  logic lin_r;
  gpmt_pkg::point_t mem_r [gpmt_pkg::MAX_ROW_POINTS];
  gpmt_pkg::point_t ur_r, ul_r, ll_r, cur_r;
  logic [LB-1:0] col_r, up_len_r;
  logic have_up_r;
  logic row_end_r;
  logic [2:0] edge_r;
  logic [2:0] n_edges_r;
  logic [PB-1:0] p1_r, p2_r;
  logic seg_r;
  logic ok1_r, ok2_r;
  logic out_valid_r;
  gpmt_pkg::out_word_t out_r;

  gpmt_pkg::len_req_t req;
  gpmt_pkg::len_rsp_t rsp;
  logic start_r;

  gpmt_edge_len u_len (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr)
      gpmt_pkg::REG_MAX_PERIMETER: cfg_prdata = 32'(max_per_r);
      gpmt_pkg::REG_LINEAR_MODE: cfg_prdata = {31'd0, lin_r};
      default: cfg_prdata = '0;
    endcase
  end

  // Edge order: triangle one uses ul-ur, ur-cur, cur-ul; triangle two adds
  // cur-ll and ll-ul and reuses cur-ul; a segment uses ll-cur.
  always_comb begin
    req.start = start_r;
    req.p = cur_r;
    req.q = ll_r;
    case (edge_r)
      3'd0: begin req.p = seg_r ? ll_r : ul_r; req.q = seg_r ? cur_r : ur_r; end
      3'd1: begin req.p = ur_r; req.q = cur_r; end
      3'd2: begin req.p = cur_r; req.q = ul_r; end
      3'd3: begin req.p = cur_r; req.q = ll_r; end
      default: begin req.p = ll_r; req.q = ul_r; end
    endcase
  end

  gpmt_pkg::point_t in_pt;
  assign in_pt = '{x: in_data.px, y: in_data.py, z: in_data.pz};

  logic [PB-1:0] root_ext;
  assign root_ext = PB'(rsp.root);

  // A new result word is loaded when the output register is free or being taken.
  logic out_load;
  assign out_load = (!out_valid_r || out_ready) &&
                    ((state_r == S_OUT1 && ok1_r) || (state_r == S_OUT2 && ok2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      max_per_r <= gpmt_pkg::PERIM_RESET;
      lin_r <= 1'b0;
      col_r <= '0;
      up_len_r <= '0;
      have_up_r <= 1'b0;
      ul_r <= '0;
      ll_r <= '0;
      ok1_r <= 1'b0;
      ok2_r <= 1'b0;
      out_valid_r <= 1'b0;
      start_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr == gpmt_pkg::REG_MAX_PERIMETER) begin
          max_per_r <= cfg_pwdata[gpmt_pkg::PERIM_BITS-1:0];
        end else if (cfg_paddr == gpmt_pkg::REG_LINEAR_MODE) begin
          lin_r <= cfg_pwdata[0];
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            logic [LB-1:0] c;
            logic [LB-1:0] ulen;
            logic hup;
            c = in_data.mesh_start ? '0 : col_r;
            ulen = in_data.mesh_start ? '0 : up_len_r;
            hup = in_data.mesh_start ? 1'b0 : have_up_r;
            cur_r <= in_pt;
            row_end_r <= in_data.row_end;
            if (c[LB-1] && in_data.row_end) begin
              up_len_r <= c;
              have_up_r <= 1'b1;
              col_r <= '0;
            end else begin
              up_len_r <= ulen;
              have_up_r <= hup;
              col_r <= c;
            end
            if (!c[LB-1]) begin
              ur_r <= mem_r[c[CB-1:0]];
              seg_r <= lin_r;
              edge_r <= 3'd0;
              p1_r <= '0;
              p2_r <= '0;
              n_edges_r <= lin_r ? 3'd1 : 3'd5;
              if (c != '0 && (lin_r || (hup && c < ulen))) begin
                state_r <= S_READ;
              end else begin
                state_r <= S_OUT2;
              end
            end
          end
        end
        S_READ: begin
          start_r <= 1'b1;
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (rsp.done) begin
            case (edge_r)
              3'd0, 3'd1: p1_r <= p1_r + root_ext;
              3'd2: begin p1_r <= p1_r + root_ext; p2_r <= p2_r + root_ext; end
              default: p2_r <= p2_r + root_ext;
            endcase
            if (edge_r + 3'd1 == n_edges_r) begin
              start_r <= 1'b0;
              state_r <= S_EDGE;
            end else begin
              edge_r <= edge_r + 3'd1;
              start_r <= 1'b1;
            end
          end else begin
            start_r <= 1'b0;
          end
        end
        S_EDGE: begin
          // Compare the finished sums; for a segment only the first is used.
          ok1_r <= (p1_r <= PB'(max_per_r));
          ok2_r <= !seg_r && (p2_r <= PB'(max_per_r));
          state_r <= S_OUT1;
        end
        S_OUT1: begin
          if (!out_valid_r || out_ready) begin
            if (ok1_r) begin
              out_r <= seg_r ?
                '{a_x: ll_r.x, a_y: ll_r.y, a_z: ll_r.z, b_x: cur_r.x, b_y: cur_r.y,
                  b_z: cur_r.z, c_x: '0, c_y: '0, c_z: '0, is_segment: 1'b1,
                  last: 1'b1} :
                '{a_x: ul_r.x, a_y: ul_r.y, a_z: ul_r.z, b_x: ur_r.x, b_y: ur_r.y,
                  b_z: ur_r.z, c_x: cur_r.x, c_y: cur_r.y, c_z: cur_r.z,
                  is_segment: 1'b0, last: !ok2_r};
            end
            ok1_r <= 1'b0;
            state_r <= S_OUT2;
          end
        end
        S_OUT2: begin
          if (!out_valid_r || out_ready) begin
            if (ok2_r) begin
              out_r <= '{a_x: cur_r.x, a_y: cur_r.y, a_z: cur_r.z, b_x: ll_r.x,
                         b_y: ll_r.y, b_z: ll_r.z, c_x: ul_r.x, c_y: ul_r.y,
                         c_z: ul_r.z, is_segment: 1'b0, last: 1'b1};
            end
            ok2_r <= 1'b0;
            // Commit the point into the line store and the neighbor registers.
            mem_r[col_r[CB-1:0]] <= cur_r;
            ul_r <= ur_r;
            ll_r <= cur_r;
            if (row_end_r) begin
              up_len_r <= col_r + LB'(1);
              have_up_r <= 1'b1;
              col_r <= '0;
            end else begin
              col_r <= col_r + LB'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  `include "grid_point_mesh_triangulator_assert.svh"

  `GPMT_ASSERT_IMP(a_no_accept_busy, state_r != S_IDLE, !in_ready, "busy but ready")
  `GPMT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data),
    "result word changed while stalled")
  `GPMT_ASSERT_IMP(a_col_range, 1'b1, col_r <= LB'(gpmt_pkg::MAX_ROW_POINTS),
    "column beyond row capacity")
endmodule
